FILE: src/pru_pkg.sv
// Package with the types, constants and the Paeth predictor for the PNG row unfilter.
package pru_pkg;

    localparam int MAX_WIDTH      = 4096;
    localparam int STORE_DEPTH    = MAX_WIDTH * 4;
    localparam int POS_W          = $clog2(STORE_DEPTH);
    localparam int CFG_WIDTH_W    = 13;
    localparam int STRIDE_W       = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W          = (STRIDE_W > CFG_WIDTH_W) ? STRIDE_W : CFG_WIDTH_W;
    localparam int CALC_W         = CMP_W + 2;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = CFG_WIDTH_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HAS_ALPHA   = 1'b1;

    localparam logic [7:0] FILTER_NONE    = 8'd0;
    localparam logic [7:0] FILTER_SUB     = 8'd1;
    localparam logic [7:0] FILTER_UP      = 8'd2;
    localparam logic [7:0] FILTER_AVERAGE = 8'd3;

    localparam logic [CALC_W-1:0] CHANNELS_RGB  = CALC_W'(3);
    localparam logic [CALC_W-1:0] CHANNELS_RGBA = CALC_W'(4);

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       frame_start;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [1:0] channel_index;
        logic       row_end;
    } out_beat_t;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic [8:0] pa;
        logic [8:0] pb;
        logic [9:0] sum_ab;
        logic [9:0] twice_c;
        logic [9:0] pc;
        logic [7:0] pick;
        pa      = (b >= c) ? {1'b0, b - c} : {1'b0, c - b};
        pb      = (a >= c) ? {1'b0, a - c} : {1'b0, c - a};
        sum_ab  = {2'b00, a} + {2'b00, b};
        twice_c = {1'b0, c, 1'b0};
        pc      = (sum_ab >= twice_c) ? sum_ab - twice_c : twice_c - sum_ab;
        if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc) begin
            pick = a;
        end else if ({1'b0, pb} <= pc) begin
            pick = b;
        end else begin
            pick = c;
        end
        return pick;
    endfunction

endpackage

FILE: src/pru_row_ram.sv
// Row store: one write port and one registered read port holding the previous row.
module pru_row_ram (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [pru_pkg::POS_W-1:0] wr_addr,
    input  logic [7:0]                wr_data,
    input  logic                      rd_en,
    input  logic [pru_pkg::POS_W-1:0] rd_addr,
    output logic [7:0]                rd_data
);
    import pru_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/png_row_unfilter_top.sv
// Top level of the PNG row unfilter: row tracking, reconstruction stage and output register.
// An accepted sample beat passes the reconstruction stage register, then the output register that drives m_data.
// Throughput: one beat per cycle unless the output stalls; the row store has single read and write ports.
// Filter beats produce no output beat and do not enter the reconstruction stage.
// Reset: row tracking, histories, output valid and configuration return to their initial values.
// The row store is not cleared; on the first row of a frame its read data is replaced by zero.
module png_row_unfilter_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pru_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  pru_pkg::in_beat_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output pru_pkg::out_beat_t              m_data
);
    import pru_pkg::*;

    logic [CFG_WIDTH_W-1:0] image_width_reg;
    logic                   has_alpha_reg;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [1:0]       mod3_reg;
    logic [1:0]       mod3_next;
    logic [7:0]       filter_reg;
    logic [7:0]       filter_next;
    logic             first_row_reg;
    logic             first_row_next;
    logic             awaiting_reg;
    logic             awaiting_next;

    logic             b_valid_reg;
    logic             b_valid_next;
    logic [7:0]       b_raw_reg;
    logic [7:0]       b_filter_reg;
    logic             b_first_reg;
    logic             b_has_left_reg;
    logic [1:0]       b_chan_reg;
    logic             b_last_reg;
    logic [POS_W-1:0] b_addr_reg;

    logic             m_valid_reg;
    logic             m_valid_next;
    out_beat_t        m_data_reg;

    logic [7:0] left_hist_reg [4];
    logic [7:0] corner_hist_reg [4];

    logic              s_accept;
    logic              take_filter;
    logic              data_accept;
    logic              b_adv;
    logic              b_fire;
    logic [CMP_W-1:0]  width_ext;
    logic [CMP_W-1:0]  width_clamped;
    logic [CALC_W-1:0] width_calc;
    logic [CALC_W-1:0] stride;
    logic [CALC_W-1:0] channels;
    logic [CALC_W-1:0] pos_ext;
    logic              last_byte;
    logic              has_left;
    logic [1:0]        chan;
    logic [7:0]        rd_data;
    logic [7:0]        above;
    logic [7:0]        left;
    logic [7:0]        corner;
    logic [7:0]        pred;
    logic [7:0]        result;
    logic [8:0]        avg_sum;

    assign b_adv       = !m_valid_reg || m_ready;
    assign b_fire      = b_valid_reg && b_adv;
    assign s_ready     = !b_valid_reg || b_adv;
    assign s_accept    = s_valid && s_ready;
    assign take_filter = awaiting_reg || s_data.frame_start;
    assign data_accept = s_accept && !take_filter;

    assign width_ext     = CMP_W'(image_width_reg);
    assign width_clamped = (width_ext == '0) ? CMP_W'(1) :
                           (width_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : width_ext;
    assign width_calc    = CALC_W'(width_clamped);
    assign stride        = has_alpha_reg ? (width_calc << 2) : (width_calc + (width_calc << 1));
    assign channels      = has_alpha_reg ? CHANNELS_RGBA : CHANNELS_RGB;
    assign pos_ext       = CALC_W'(pos_reg);
    assign last_byte     = (pos_ext + CALC_W'(1)) >= stride;
    assign has_left      = pos_ext >= channels;
    assign chan          = has_alpha_reg ? pos_reg[1:0] : mod3_reg;

    always_comb begin
        pos_next       = pos_reg;
        mod3_next      = mod3_reg;
        filter_next    = filter_reg;
        first_row_next = first_row_reg;
        awaiting_next  = awaiting_reg;
        if (s_accept) begin
            if (take_filter) begin
                filter_next   = s_data.raw_byte;
                awaiting_next = 1'b0;
                pos_next      = '0;
                mod3_next     = 2'd0;
                if (s_data.frame_start) begin
                    first_row_next = 1'b1;
                end
            end else if (last_byte) begin
                pos_next       = '0;
                mod3_next      = 2'd0;
                awaiting_next  = 1'b1;
                first_row_next = 1'b0;
            end else begin
                pos_next  = pos_reg + POS_W'(1);
                mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            end
        end
    end

    always_comb begin
        b_valid_next = b_valid_reg;
        if (s_accept) begin
            b_valid_next = !take_filter;
        end else if (b_adv) begin
            b_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (b_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= CFG_WIDTH_W'(1);
            has_alpha_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: image_width_reg <= cfg_wr_data[CFG_WIDTH_W-1:0];
                CFG_HAS_ALPHA:   has_alpha_reg   <= cfg_wr_data[0];
                default:         has_alpha_reg   <= has_alpha_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            mod3_reg      <= 2'd0;
            filter_reg    <= FILTER_NONE;
            first_row_reg <= 1'b1;
            awaiting_reg  <= 1'b1;
            b_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            mod3_reg      <= mod3_next;
            filter_reg    <= filter_next;
            first_row_reg <= first_row_next;
            awaiting_reg  <= awaiting_next;
            b_valid_reg   <= b_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (data_accept) begin
            b_raw_reg      <= s_data.raw_byte;
            b_filter_reg   <= filter_reg;
            b_first_reg    <= first_row_reg;
            b_has_left_reg <= has_left;
            b_chan_reg     <= chan;
            b_last_reg     <= last_byte;
            b_addr_reg     <= pos_reg;
        end
    end

    pru_row_ram u_row_ram (
        .aclk    (aclk),
        .wr_en   (b_fire),
        .wr_addr (b_addr_reg),
        .wr_data (result),
        .rd_en   (data_accept),
        .rd_addr (pos_reg),
        .rd_data (rd_data)
    );

    assign above   = b_first_reg ? 8'd0 : rd_data;
    assign left    = b_has_left_reg ? left_hist_reg[b_chan_reg] : 8'd0;
    assign corner  = (b_has_left_reg && !b_first_reg) ? corner_hist_reg[b_chan_reg] : 8'd0;
    assign avg_sum = {1'b0, left} + {1'b0, above};

    always_comb begin
        unique case (b_filter_reg)
            FILTER_NONE:    pred = 8'd0;
            FILTER_SUB:     pred = left;
            FILTER_UP:      pred = above;
            FILTER_AVERAGE: pred = avg_sum[8:1];
            default:        pred = paeth_pick(left, above, corner);
        endcase
    end

    assign result = b_raw_reg + pred;

    // A frame start clears the histories; the clear wins over an update from a byte firing in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn || (s_accept && s_data.frame_start)) begin
            for (int i = 0; i < 4; i++) begin
                left_hist_reg[i]   <= 8'd0;
                corner_hist_reg[i] <= 8'd0;
            end
        end else if (b_fire) begin
            left_hist_reg[b_chan_reg]   <= result;
            corner_hist_reg[b_chan_reg] <= above;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire) begin
            m_data_reg.pixel_byte    <= result;
            m_data_reg.channel_index <= b_chan_reg;
            m_data_reg.row_end       <= b_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_same_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (data_accept && b_fire) |-> (pos_reg != b_addr_reg))
        else $error("row store read and write hit the same entry");

    a_filter_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && take_filter) |=> !b_valid_reg)
        else $error("filter beat entered the reconstruction stage");

    a_sample_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        data_accept |=> b_valid_reg)
        else $error("sample beat was lost");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_adv) |=> (b_valid_reg && $stable(b_addr_reg) && $stable(rd_data)))
        else $error("stalled reconstruction stage changed");

    a_fire_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        b_fire |=> m_valid_reg)
        else $error("reconstructed byte did not reach the output register");

endmodule

FILE: test/tb_png_row_unfilter_top.sv
// Self-checking testbench for the PNG row unfilter: predicts and checks every output byte.
`timescale 1ns / 1ps

module tb_png_row_unfilter_top;
    import pru_pkg::*;

    localparam logic [7:0] FILTER_PAETH = 8'd4;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 500000;

    class unfilter_scoreboard;
        bit [7:0]    upper_row [STORE_DEPTH];
        int unsigned position;
        bit [7:0]    filter_code;
        bit          first_row;
        bit          want_filter;
        bit [7:0]    left_bytes [4];
        bit [7:0]    corner_bytes [4];
        bit [12:0]   width_reg;
        bit          alpha_reg;
        out_beat_t   expected_pixels [$];
        int unsigned mismatches;
        int unsigned pixels_checked;
        int unsigned row_ends;

        function new();
            width_reg = 13'd1;
            alpha_reg = 1'b0;
            restart_frame();
        endfunction

        function void restart_frame();
            position = 0;
            filter_code = FILTER_NONE;
            first_row = 1'b1;
            want_filter = 1'b1;
            for (int i = 0; i < 4; i++) begin
                left_bytes[i] = 8'd0;
                corner_bytes[i] = 8'd0;
            end
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            if (index == CFG_IMAGE_WIDTH) begin
                width_reg = value[12:0];
            end else if (index == CFG_HAS_ALPHA) begin
                alpha_reg = value[0];
            end
        endfunction

        function int unsigned row_length();
            int unsigned pixels;
            pixels = (width_reg == 0) ? 1 : width_reg;
            if (pixels > MAX_WIDTH) begin
                pixels = MAX_WIDTH;
            end
            return pixels * (alpha_reg ? 4 : 3);
        endfunction

        function bit [7:0] paeth_choice(bit [7:0] a, bit [7:0] b, bit [7:0] c);
            int est;
            int da;
            int db;
            int dc;
            est = int'(a) + int'(b) - int'(c);
            da = est - int'(a);
            db = est - int'(b);
            dc = est - int'(c);
            if (da < 0) da = -da;
            if (db < 0) db = -db;
            if (dc < 0) dc = -dc;
            if (da <= db && da <= dc) begin
                return a;
            end else if (db <= dc) begin
                return b;
            end
            return c;
        endfunction

        function void note_input(in_beat_t beat);
            int unsigned chans;
            int unsigned stride;
            int unsigned p;
            int unsigned ch;
            bit [7:0]    left;
            bit [7:0]    above;
            bit [7:0]    corner;
            bit [7:0]    pred;
            bit [8:0]    pair_sum;
            bit          last;
            out_beat_t   pixel;
            chans = alpha_reg ? 4 : 3;
            stride = row_length();
            if (beat.frame_start) begin
                restart_frame();
            end
            if (want_filter) begin
                filter_code = beat.raw_byte;
                want_filter = 1'b0;
                position = 0;
                return;
            end
            p = (position >= STORE_DEPTH) ? STORE_DEPTH - 1 : position;
            ch = p % chans;
            above = first_row ? 8'd0 : upper_row[p];
            left = (p >= chans) ? left_bytes[ch] : 8'd0;
            corner = (p >= chans && !first_row) ? corner_bytes[ch] : 8'd0;
            case (filter_code)
                FILTER_NONE: begin
                    pred = 8'd0;
                end
                FILTER_SUB: begin
                    pred = left;
                end
                FILTER_UP: begin
                    pred = above;
                end
                FILTER_AVERAGE: begin
                    pair_sum = {1'b0, left} + {1'b0, above};
                    pred = pair_sum[8:1];
                end
                default: begin
                    pred = paeth_choice(left, above, corner);
                end
            endcase
            pixel.pixel_byte = beat.raw_byte + pred;
            left_bytes[ch] = pixel.pixel_byte;
            corner_bytes[ch] = above;
            upper_row[p] = pixel.pixel_byte;
            last = (p + 1 >= stride);
            if (last) begin
                position = 0;
                want_filter = 1'b1;
                first_row = 1'b0;
            end else begin
                position = p + 1;
            end
            pixel.channel_index = ch[1:0];
            pixel.row_end = last;
            expected_pixels.push_back(pixel);
        endfunction

        function void check_output(out_beat_t got);
            out_beat_t want;
            if (expected_pixels.size() == 0) begin
                $error("Output beat with nothing expected: pixel_byte %0d", got.pixel_byte);
                mismatches++;
                return;
            end
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (want.row_end) row_ends++;
            if (got.pixel_byte !== want.pixel_byte) begin
                $error("pixel_byte mismatch: expected %0d, actual %0d",
                       want.pixel_byte, got.pixel_byte);
                mismatches++;
            end
            if (got.channel_index !== want.channel_index) begin
                $error("channel_index mismatch: expected %0d, actual %0d",
                       want.channel_index, got.channel_index);
                mismatches++;
            end
            if (got.row_end !== want.row_end) begin
                $error("row_end mismatch: expected %0d, actual %0d", want.row_end, got.row_end);
                mismatches++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   s_valid;
    logic                   s_ready;
    in_beat_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_beat_t              m_data;

    unfilter_scoreboard board;
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;
    bit                 hold_results;
    int unsigned        items_sent;
    int unsigned        settings_written;
    int unsigned        cycles;

    png_row_unfilter_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) board.check_output(m_data);
            if (s_valid && s_ready) board.note_input(s_data);
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end else begin
                m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_beat(input logic [7:0] raw, input logic start);
        in_beat_t beat;
        beat.raw_byte = raw;
        beat.frame_start = start;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_geometry(input int unsigned width, input logic alpha);
        logic [CFG_DATA_W-1:0] alpha_word;
        alpha_word = CFG_DATA_W'($urandom);
        alpha_word[0] = alpha;
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_wr_data <= width[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_index <= CFG_HAS_ALPHA;
        cfg_wr_data <= alpha_word;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_register(CFG_IMAGE_WIDTH, width[CFG_DATA_W-1:0]);
        board.set_register(CFG_HAS_ALPHA, alpha_word);
        settings_written++;
    endtask

    function automatic logic [7:0] pick_filter();
        int unsigned roll;
        roll = $urandom_range(11);
        case (roll)
            0, 1:    return FILTER_NONE;
            2, 3:    return FILTER_SUB;
            4, 5:    return FILTER_UP;
            6, 7:    return FILTER_AVERAGE;
            8, 9:    return FILTER_PAETH;
            10:      return 8'hFF;
            default: return 8'($urandom_range(255, 5));
        endcase
    endfunction

    function automatic logic [7:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(7);
        if (roll == 0) return 8'h00;
        if (roll == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_stream(input int count, input bit open_frame, input int restart_permil);
        int unsigned stride;
        int unsigned pos;
        logic        start;
        stride = board.row_length();
        pos = 0;
        for (int i = 0; i < count; i++) begin
            start = (i == 0 && open_frame) || ($urandom_range(999) < restart_permil);
            if (start) pos = 0;
            send_beat((pos == 0) ? pick_filter() : pick_sample(), start);
            pos = (pos == stride) ? 0 : pos + 1;
        end
    endtask

    task automatic run_phase(input int unsigned width, input logic alpha, input int sidle,
                             input int rstall, input int count, input bit with_pressure);
        program_geometry(width, alpha);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        if (with_pressure) begin
            send_stream(count / 2, 1'b1, 4);
            settle();
            hold_results = 1'b1;
            send_stream(count - count / 2, 1'b0, 4);
        end else begin
            send_stream(count, 1'b1, 4);
        end
        settle();
    endtask

    initial begin
        board = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_results = 1'b0;
        items_sent = 0;
        settings_written = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // The opening rows run on the reset geometry of one RGB pixel per row.
        send_beat(FILTER_NONE, 1'b1);
        send_beat(8'hFF, 1'b0); send_beat(8'h00, 1'b0); send_beat(8'h80, 1'b0);
        send_beat(FILTER_SUB, 1'b0);
        send_beat(8'h01, 1'b0); send_beat(8'hFF, 1'b0); send_beat(8'h7F, 1'b0);
        send_beat(FILTER_UP, 1'b0);
        send_beat(8'h01, 1'b0); send_beat(8'h01, 1'b0); send_beat(8'h80, 1'b0);
        send_beat(FILTER_AVERAGE, 1'b0);
        send_beat(8'hFF, 1'b0); send_beat(8'h00, 1'b0); send_beat(8'h81, 1'b0);
        send_beat(FILTER_PAETH, 1'b0);
        send_beat(8'h00, 1'b0); send_beat(8'hFF, 1'b0); send_beat(8'h7F, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h01, 1'b0); send_beat(8'h80, 1'b0); send_beat(8'hFE, 1'b0);
        send_beat(FILTER_SUB, 1'b0);
        send_beat(8'h10, 1'b0);
        send_beat(FILTER_UP, 1'b1);
        send_beat(8'h05, 1'b0); send_beat(8'h06, 1'b0); send_beat(8'h07, 1'b0);
        settle();

        run_phase(0, 1'b1, 0, 0, 150, 1'b0);
        run_phase(1, 1'b0, 63, 0, 150, 1'b0);
        run_phase(3, 1'b1, 0, 63, 150, 1'b0);
        run_phase($urandom_range(12, 2), 1'b0, 35, 35, 150, 1'b0);
        run_phase(5, 1'b1, 0, 0, 150, 1'b1);
        run_phase($urandom_range(20, 1), 1'($urandom_range(1)), 63, 0, 150, 1'b0);
        run_phase(16, 1'b0, 0, 63, 150, 1'b0);
        run_phase(7, 1'b1, 35, 35, 150, 1'b0);

        // Stop inside the second row, then shrink the row so the next beat closes it.
        program_geometry(10, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 35;
        send_stream(52, 1'b1, 0);
        settle();
        program_geometry(4, 1'b1);
        send_stream(60, 1'b0, 0);
        settle();

        recv_stall_pct = 0;
        program_geometry(8191, 1'b1);
        send_stream(60, 1'b1, 0);
        settle();
        program_geometry(4096, 1'b0);
        send_stream(60, 1'b1, 0);
        settle();

        $display("Covered %0d input beats over %0d register settings,", items_sent,
                 settings_written);
        $display("row widths from zero to past the store; checked %0d bytes, %0d closing a row.",
                 board.pixels_checked, board.row_ends);
        if (board.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
src/pru_pkg.sv
src/pru_row_ram.sv
src/png_row_unfilter_top.sv
test/tb_png_row_unfilter_top.sv
